>>> src/fpvm_pkg.sv
package fpvm_pkg;

    // Field and datapath widths.
    localparam int ANG_IN_W   = 16;
    localparam int UQ_W       = 16;
    localparam int MAG_W      = 17;
    localparam int TRIG_W     = 16;
    localparam int AB_W       = 32;
    localparam int PP_W       = 7;
    localparam int UMAX_W     = 15;
    localparam int U_W        = 48;
    localparam int DUTY_OUT_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Quarter-wave sine polynomial coefficients, Q15.
    localparam logic [15:0] SIN_A   = 16'd51472;
    localparam logic [14:0] SIN_B   = 15'd21024;
    localparam logic [11:0] SIN_C   = 12'd2320;
    localparam logic [15:0] Q15_ONE = 16'h8000;
    localparam logic [16:0] SIN_MAX = 17'd32767;

    // Transform constants, Q15.
    localparam logic [15:0] K_INV_SQRT3     = 16'd18919;
    localparam logic [15:0] K_TWO_INV_SQRT3 = 16'd37837;
    localparam logic [15:0] K_SQRT3_HALF    = 16'd28378;

    // Largest phase of sectors I and III on a 32-bit turn.
    localparam logic [31:0] SECT_I_MAX   = 32'd1431655765;
    localparam logic [31:0] SECT_III_MAX = 32'd2863311530;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_U_MAX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVER_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        SECT_I   = 2'd0,
        SECT_II  = 2'd1,
        SECT_III = 2'd2
    } sector_t;

    typedef struct packed {
        logic                       valid;
        logic                       mode;
        logic signed [UQ_W-1:0]     uq;
        logic        [ANG_IN_W-1:0] angle;
    } in_t;

    typedef struct packed {
        logic                   valid;
        sector_t                sector;
        logic signed [AB_W-1:0] alpha;
        logic signed [AB_W-1:0] beta;
    } ab_t;

    typedef struct packed {
        logic                  valid;
        logic signed [U_W-1:0] ua;
        logic signed [U_W-1:0] ub;
        logic signed [U_W-1:0] uc;
    } uvw_t;

    typedef struct packed {
        logic                  valid;
        logic [DUTY_OUT_W-1:0] duty_a;
        logic [DUTY_OUT_W-1:0] duty_b;
        logic [DUTY_OUT_W-1:0] duty_c;
    } duty_t;

endpackage

>>> src/fpvm_angle_sine.sv
module fpvm_angle_sine
    import fpvm_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  in_t             in_item,
    input  logic [PP_W-1:0] pair_count,
    output ab_t             out_item
);

    localparam int PROD_W   = ANGLE_BITS + ANG_IN_W + PP_W;
    localparam int PH_SHIFT = 32 - ANGLE_BITS;

    // Stage 1: electrical angle, half-turn flip, magnitude, sector.
    logic [PROD_W-1:0]     ang_w;
    logic [PROD_W-1:0]     prod_w;
    logic [ANGLE_BITS-1:0] el;
    logic [31:0]           ph_base;
    logic [31:0]           ph_next;
    logic                  nonpos;
    logic signed [UQ_W:0]  uq_x;
    logic [MAG_W-1:0]      mag_next;
    sector_t               sector_next;

    logic [16:0]      ph_reg;
    logic [MAG_W-1:0] mag1_reg;
    sector_t          sect1_reg;

    always_comb begin
        ang_w    = PROD_W'(in_item.angle);
        prod_w   = ang_w * PROD_W'(pair_count);
        el       = in_item.mode ? ang_w[ANGLE_BITS-1:0] : prod_w[ANGLE_BITS-1:0];
        ph_base  = {el, {PH_SHIFT{1'b0}}};
        nonpos   = in_item.uq[UQ_W-1] || (in_item.uq == '0);
        ph_next  = ph_base ^ {nonpos, 31'b0};
        uq_x     = {in_item.uq[UQ_W-1], in_item.uq};
        mag_next = uq_x[UQ_W] ? MAG_W'(-uq_x) : MAG_W'(uq_x);
        if (ph_next <= SECT_I_MAX) begin
            sector_next = SECT_I;
        end else if (ph_next <= SECT_III_MAX) begin
            sector_next = SECT_III;
        end else begin
            sector_next = SECT_II;
        end
    end

    // Lane 0 is the sine, lane 1 the cosine (phase plus a quarter turn).
    // Stage 2: fold into the first quadrant and square.
    logic [1:0][1:0]  quad;
    logic [1:0][15:0] z_next;
    logic [1:0][15:0] z2_next;
    logic [1:0][31:0] zz_prod;

    logic [1:0][15:0] z2_reg;
    logic [1:0][15:0] z2_z_reg;
    logic [1:0]       z2_neg_reg;
    logic [MAG_W-1:0] mag2_reg;
    sector_t          sect2_reg;

    always_comb begin
        quad[0] = ph_reg[16:15];
        quad[1] = ph_reg[16:15] + 2'd1;
        for (int l = 0; l < 2; l++) begin
            z_next[l]  = quad[l][0] ? (Q15_ONE - {1'b0, ph_reg[14:0]}) : {1'b0, ph_reg[14:0]};
            zz_prod[l] = 32'(z_next[l]) * 32'(z_next[l]);
            z2_next[l] = zz_prod[l][30:15];
        end
    end

    // Stage 3: B - C*z^2.
    logic [1:0][27:0] c_prod;
    logic [1:0][14:0] t1_next;

    logic [1:0][14:0] t1_reg;
    logic [1:0][15:0] t1_z2_reg;
    logic [1:0][15:0] t1_z_reg;
    logic [1:0]       t1_neg_reg;
    logic [MAG_W-1:0] mag3_reg;
    sector_t          sect3_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            c_prod[l]  = 28'(SIN_C) * 28'(z2_reg[l]);
            t1_next[l] = SIN_B - 15'(c_prod[l][27:15]);
        end
    end

    // Stage 4: A - t1*z^2.
    logic [1:0][30:0] b_prod;
    logic [1:0][15:0] t3_next;

    logic [1:0][15:0] t3_reg;
    logic [1:0][15:0] t3_z_reg;
    logic [1:0]       t3_neg_reg;
    logic [MAG_W-1:0] mag4_reg;
    sector_t          sect4_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            b_prod[l]  = 31'(t1_reg[l]) * 31'(t1_z2_reg[l]);
            t3_next[l] = SIN_A - b_prod[l][30:15];
        end
    end

    // Stage 5: times z, clamp to full scale, sign by half-turn.
    logic [1:0][31:0]        a_prod;
    logic [1:0][16:0]        t4;
    logic [1:0][14:0]        s15;
    logic [1:0][TRIG_W-1:0]  trig_next;

    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic [MAG_W-1:0]         mag5_reg;
    sector_t                  sect5_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            a_prod[l] = 32'(t3_reg[l]) * 32'(t3_z_reg[l]);
            t4[l]     = a_prod[l][31:15];
            s15[l]    = (t4[l] > SIN_MAX) ? SIN_MAX[14:0] : t4[l][14:0];
            trig_next[l] = t3_neg_reg[l] ? TRIG_W'(-{1'b0, s15[l]}) : {1'b0, s15[l]};
        end
    end

    // Stage 6: alpha and beta.
    logic signed [AB_W-1:0] alpha_next;
    logic signed [AB_W-1:0] beta_next;
    logic signed [AB_W-1:0] alpha_reg;
    logic signed [AB_W-1:0] beta_reg;
    sector_t                sect6_reg;

    always_comb begin
        alpha_next = AB_W'($signed({1'b0, mag5_reg})) * AB_W'(cos_reg);
        beta_next  = AB_W'($signed({1'b0, mag5_reg})) * AB_W'(sin_reg);
    end

    logic [5:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_item.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg     <= ph_next[31:15];
            mag1_reg   <= mag_next;
            sect1_reg  <= sector_next;

            z2_reg     <= z2_next;
            z2_z_reg   <= z_next;
            z2_neg_reg <= {quad[1][1], quad[0][1]};
            mag2_reg   <= mag1_reg;
            sect2_reg  <= sect1_reg;

            t1_reg     <= t1_next;
            t1_z2_reg  <= z2_reg;
            t1_z_reg   <= z2_z_reg;
            t1_neg_reg <= z2_neg_reg;
            mag3_reg   <= mag2_reg;
            sect3_reg  <= sect2_reg;

            t3_reg     <= t3_next;
            t3_z_reg   <= t1_z_reg;
            t3_neg_reg <= t1_neg_reg;
            mag4_reg   <= mag3_reg;
            sect4_reg  <= sect3_reg;

            sin_reg    <= trig_next[0];
            cos_reg    <= trig_next[1];
            mag5_reg   <= mag4_reg;
            sect5_reg  <= sect4_reg;

            alpha_reg  <= alpha_next;
            beta_reg   <= beta_next;
            sect6_reg  <= sect5_reg;
        end
    end

    assign out_item.valid  = valid_reg[5];
    assign out_item.sector = sect6_reg;
    assign out_item.alpha  = alpha_reg;
    assign out_item.beta   = beta_reg;

endmodule

>>> src/fpvm_phase_mix.sv
module fpvm_phase_mix
    import fpvm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic driver_mode,
    input  ab_t  in_item,
    output uvw_t out_item
);

    // Stage 1: constant products of beta.
    logic signed [U_W-1:0] beta_w;
    logic signed [U_W-1:0] pb_inv_next;
    logic signed [U_W-1:0] pb_two_next;
    logic signed [U_W-1:0] pb_half_next;

    logic signed [U_W-1:0] alpha_reg;
    logic signed [U_W-1:0] pb_inv_reg;
    logic signed [U_W-1:0] pb_two_reg;
    logic signed [U_W-1:0] pb_half_reg;
    sector_t               sect_reg;

    always_comb begin
        beta_w       = U_W'(in_item.beta);
        pb_inv_next  = beta_w * $signed(U_W'(K_INV_SQRT3));
        pb_two_next  = beta_w * $signed(U_W'(K_TWO_INV_SQRT3));
        pb_half_next = beta_w * $signed(U_W'(K_SQRT3_HALF));
    end

    // Stage 2: phase voltages, inverse Clarke or sector scheme.
    logic signed [U_W-1:0] a15;
    logic signed [U_W-1:0] a14;
    logic signed [U_W-1:0] ua_next;
    logic signed [U_W-1:0] ub_next;
    logic signed [U_W-1:0] uc_next;

    logic signed [U_W-1:0] ua_reg;
    logic signed [U_W-1:0] ub_reg;
    logic signed [U_W-1:0] uc_reg;

    always_comb begin
        a15 = alpha_reg <<< 15;
        a14 = alpha_reg <<< 14;
        if (!driver_mode) begin
            ua_next = a15;
            ub_next = pb_half_reg - a14;
            uc_next = -a14 - pb_half_reg;
        end else begin
            case (sect_reg)
                SECT_I: begin
                    ua_next = a15 + pb_inv_reg;
                    ub_next = pb_two_reg;
                    uc_next = '0;
                end
                SECT_III: begin
                    ua_next = '0;
                    ub_next = pb_inv_reg - a15;
                    uc_next = -pb_inv_reg - a15;
                end
                default: begin
                    ua_next = a15 - pb_inv_reg;
                    ub_next = '0;
                    uc_next = -pb_two_reg;
                end
            endcase
        end
    end

    logic [1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_item.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha_reg   <= U_W'(in_item.alpha);
            pb_inv_reg  <= pb_inv_next;
            pb_two_reg  <= pb_two_next;
            pb_half_reg <= pb_half_next;
            sect_reg    <= in_item.sector;
            ua_reg      <= ua_next;
            ub_reg      <= ub_next;
            uc_reg      <= uc_next;
        end
    end

    assign out_item.valid = valid_reg[1];
    assign out_item.ua    = ua_reg;
    assign out_item.ub    = ub_reg;
    assign out_item.uc    = uc_reg;

endmodule

>>> src/fpvm_duty_div.sv
module fpvm_duty_div
    import fpvm_pkg::*;
#(
    parameter int DUTY_MAX = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [UMAX_W-1:0] u_max,
    input  logic              driver_mode,
    input  uvw_t              in_item,
    output duty_t             out_item
);

    localparam int DW    = $clog2(DUTY_MAX + 1);
    localparam int XP_W  = U_W - 1;
    localparam int N_W   = U_W + DW;
    localparam int NQ_W  = N_W - 31;
    localparam int NSTG  = DW + 4;

    localparam logic [DW-1:0] DMAX = DW'(DUTY_MAX);

    logic [UMAX_W-1:0] um;
    assign um = (u_max == '0) ? UMAX_W'(1) : u_max;

    logic signed [U_W-1:0] u_lane [3];
    assign u_lane[0] = in_item.ua;
    assign u_lane[1] = in_item.ub;
    assign u_lane[2] = in_item.uc;

    // Stage 1: bipolar offset by u_max, non-positive numerators give zero duty.
    logic signed [U_W-1:0] umq;
    logic signed [U_W-1:0] x_next [3];
    logic [2:0]            zero_next;
    logic [XP_W-1:0]       x_reg [3];
    logic [2:0]            zero1_reg;

    always_comb begin
        umq = $signed(U_W'(um)) <<< 30;
        for (int l = 0; l < 3; l++) begin
            x_next[l]    = driver_mode ? u_lane[l] : u_lane[l] + umq;
            zero_next[l] = x_next[l][U_W-1] || (x_next[l] == '0);
        end
    end

    // Stage 2: scale by full duty and drop the fixed 2^30 (or 2^31) of the divisor.
    logic [N_W-1:0]  n_prod [3];
    logic [NQ_W-1:0] nq_next [3];
    logic [NQ_W-1:0] nq_reg [3];
    logic [2:0]      zero2_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_prod[l]  = N_W'(x_reg[l]) * N_W'(DUTY_MAX);
            nq_next[l] = driver_mode ? n_prod[l][30 +: NQ_W] : n_prod[l][31 +: NQ_W];
        end
    end

    // Division stages: index 0 holds the saturation check, index j the
    // remainder after quotient bit DW-j.
    logic [NQ_W-1:0] r_reg    [DW+1][3];
    logic [DW-1:0]   q_reg    [DW+1][3];
    logic [2:0]      sat_reg  [DW+1];
    logic [2:0]      zdiv_reg [DW+1];

    logic [NQ_W-1:0] um_top;
    logic [2:0]      sat_next;

    always_comb begin
        um_top = NQ_W'(um) << DW;
        for (int l = 0; l < 3; l++) begin
            sat_next[l] = (nq_reg[l] >= um_top);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                x_reg[l]    <= x_next[l][XP_W-1:0];
                nq_reg[l]   <= nq_next[l];
                r_reg[0][l] <= nq_reg[l];
                q_reg[0][l] <= '0;
            end
            zero1_reg   <= zero_next;
            zero2_reg   <= zero1_reg;
            sat_reg[0]  <= sat_next;
            zdiv_reg[0] <= zero2_reg;
        end
    end

    for (genvar j = 1; j <= DW; j++) begin : g_div
        localparam int K = DW - j;
        logic [NQ_W-1:0] divisor;
        logic [NQ_W-1:0] r_next [3];
        logic [DW-1:0]   q_next [3];

        always_comb begin
            divisor = NQ_W'(um) << K;
            for (int l = 0; l < 3; l++) begin
                if (r_reg[j-1][l] >= divisor) begin
                    r_next[l]    = r_reg[j-1][l] - divisor;
                    q_next[l]    = q_reg[j-1][l];
                    q_next[l][K] = 1'b1;
                end else begin
                    r_next[l] = r_reg[j-1][l];
                    q_next[l] = q_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 3; l++) begin
                    r_reg[j][l] <= r_next[l];
                    q_reg[j][l] <= q_next[l];
                end
                sat_reg[j]  <= sat_reg[j-1];
                zdiv_reg[j] <= zdiv_reg[j-1];
            end
        end
    end

    // Final stage: clamp to 0..DUTY_MAX and keep the low byte.
    logic [DW-1:0]         d_next    [3];
    logic [DUTY_OUT_W-1:0] duty_next [3];
    logic [DUTY_OUT_W-1:0] duty_reg  [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (zdiv_reg[DW][l]) begin
                d_next[l] = '0;
            end else if (sat_reg[DW][l] || (q_reg[DW][l] > DMAX)) begin
                d_next[l] = DMAX;
            end else begin
                d_next[l] = q_reg[DW][l];
            end
            duty_next[l] = d_next[l][DUTY_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                duty_reg[l] <= duty_next[l];
            end
        end
    end

    logic [NSTG-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTG-2:0], in_item.valid};
        end
    end

    assign out_item.valid  = valid_reg[NSTG-1];
    assign out_item.duty_a = duty_reg[0];
    assign out_item.duty_b = duty_reg[1];
    assign out_item.duty_c = duty_reg[2];

endmodule

>>> src/foc_phase_voltage_modulator.sv
// Channel  | Direction | tdata (low bit up)                       | tuser
// s_axis   | in        | uq [15:0] signed, angle [31:16]          | mode [0]
// m_axis   | out       | duty_a [7:0], duty_b [15:8], duty_c [23:16] | -
// cfg      | in        | cfg_index 0 u_max, 1 driver_mode, 2 pair_count; no read-back
//
// One transaction is accepted per clock while s_axis_tready is high. The pipeline has
// six stages for angle and sine, two for the phase transform, and a restoring
// divider by u_max that retires one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults.
// s_axis_tready drops only while the output register holds an untaken result and
// the last pipeline stage is full; then every stage holds its contents.
module foc_phase_voltage_modulator
    import fpvm_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int DUTY_MAX   = 255
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // uq [15:0], angle [31:16]
    input  logic                 s_axis_tuser,   // mode [0]

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // duty_a [7:0], duty_b [15:8], duty_c [23:16]

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UMAX_W-1:0]    cfg_wdata
);

    logic [UMAX_W-1:0] u_max_reg;
    logic              driver_mode_reg;
    logic [PP_W-1:0]   pair_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_max_reg       <= UMAX_W'(3072);
            driver_mode_reg <= 1'b0;
            pair_count_reg  <= PP_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_U_MAX:       u_max_reg       <= cfg_wdata;
                REG_DRIVER_MODE: driver_mode_reg <= cfg_wdata[0];
                REG_PAIR_COUNT:  pair_count_reg  <= cfg_wdata[PP_W-1:0];
                default: ;
            endcase
        end
    end

    logic  en;
    logic  out_free;
    in_t   in_item;
    ab_t   ab_q;
    uvw_t  uvw_q;
    duty_t duty_q;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign en            = out_free || !duty_q.valid;
    assign s_axis_tready = en;

    assign in_item.valid = s_axis_tvalid && en;
    assign in_item.mode  = s_axis_tuser;
    assign in_item.uq    = s_axis_tdata[15:0];
    assign in_item.angle = s_axis_tdata[31:16];

    fpvm_angle_sine #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_angle_sine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_item    (in_item),
        .pair_count (pair_count_reg),
        .out_item   (ab_q)
    );

    fpvm_phase_mix u_phase_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .driver_mode (driver_mode_reg),
        .in_item     (ab_q),
        .out_item    (uvw_q)
    );

    fpvm_duty_div #(
        .DUTY_MAX (DUTY_MAX)
    ) u_duty_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .u_max       (u_max_reg),
        .driver_mode (driver_mode_reg),
        .in_item     (uvw_q),
        .out_item    (duty_q)
    );

    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= duty_q.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= {duty_q.duty_c, duty_q.duty_b, duty_q.duty_a};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only comes from a held result with the pipeline end full.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && duty_q.valid))
        else $error("input stalled without an output stall");

    // A stalled pipeline keeps its finished transaction unchanged.
    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (duty_q.valid && !s_axis_tready) |=> (duty_q.valid && $stable(duty_q.duty_a)
            && $stable(duty_q.duty_b) && $stable(duty_q.duty_c)))
        else $error("pipeline end changed during a stall");

endmodule

>>> dv/tb_foc_phase_voltage_modulator.sv
module tb_foc_phase_voltage_modulator;
    import fpvm_pkg::*;

    localparam int ANGLE_W         = 16;
    localparam int DUTY_FULL       = 255;
    localparam int ROUNDS          = 14;
    localparam int ITEMS_PER_ROUND = 125;
    localparam int SETTLE_CYCLES   = 25;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Signed copies of the Q15 constants so products stay signed.
    localparam longint ONE_Q15   = Q15_ONE;
    localparam longint HALF_Q15  = 16384;
    localparam longint INV_S3    = K_INV_SQRT3;
    localparam longint TWO_INV_S3 = K_TWO_INV_SQRT3;
    localparam longint S3_HALF   = K_SQRT3_HALF;

    typedef struct packed {
        logic [7:0] duty_c;
        logic [7:0] duty_b;
        logic [7:0] duty_a;
    } duty_triple_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;    // uq [15:0], angle [31:16]
    logic                 s_axis_tuser = 1'b0;  // mode [0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;         // duty_a [7:0], duty_b [15:8], duty_c [23:16]
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [UMAX_W-1:0]    cfg_wdata = '0;

    // Register copies used for prediction.
    logic [14:0] umax_reg;
    logic        drive_unipolar;
    logic [6:0]  pole_pair_reg;

    duty_triple_t pending_duties[$];
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int cfg_write_count = 0;
    int idle_cycles = 0;

    foc_phase_voltage_modulator #(
        .ANGLE_BITS(ANGLE_W),
        .DUTY_MAX  (DUTY_FULL)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Odd polynomial over the first quarter turn, every product truncated.
    function automatic longint quarter_sine(input longint unsigned z);
        longint unsigned z2;
        longint unsigned t;
        z2 = (z * z) >> 15;
        t = (64'(SIN_C) * z2) >> 15;
        t = 64'(SIN_B) - t;
        t = (t * z2) >> 15;
        t = 64'(SIN_A) - t;
        t = (t * z) >> 15;
        if (t > 64'd32767)
            t = 64'd32767;
        return longint'(t);
    endfunction

    function automatic longint phase_sine(input logic [31:0] ph);
        longint unsigned z;
        longint s;
        z = ph[29:15];
        s = ph[30] ? quarter_sine(64'(Q15_ONE) - z) : quarter_sine(z);
        return ph[31] ? -s : s;
    endfunction

    function automatic logic [7:0] scale_to_duty(input longint u, input longint full_q30,
                                                 input logic unipolar);
        longint d;
        if (unipolar)
            d = (u * DUTY_FULL) / full_q30;
        else
            d = ((u + full_q30) * DUTY_FULL) / (2 * full_q30);
        if (d < 0)
            d = 0;
        if (d > DUTY_FULL)
            d = DUTY_FULL;
        return 8'(d);
    endfunction

    function automatic duty_triple_t predict_duties(input logic mode,
                                                    input logic signed [15:0] uq,
                                                    input logic [15:0] angle);
        logic [15:0]  el;
        logic [31:0]  ph;
        longint       uq_l, mag, c, s, alpha, beta, ua, ub, uc, full_q30;
        sector_t      sect;
        duty_triple_t r;
        el = mode ? angle : 16'(32'(angle) * pole_pair_reg);
        ph = {el, 16'h0000};
        uq_l = uq;
        mag = (uq_l < 0) ? -uq_l : uq_l;
        // A voltage that is not positive turns the vector by half a turn.
        if (uq_l <= 0)
            ph = ph + 32'h8000_0000;
        c = phase_sine(ph + 32'h4000_0000);
        s = phase_sine(ph);
        alpha = mag * c;
        beta = mag * s;
        if (drive_unipolar) begin
            if (ph <= SECT_I_MAX)
                sect = SECT_I;
            else if (ph <= SECT_III_MAX)
                sect = SECT_III;
            else
                sect = SECT_II;
            case (sect)
                SECT_I: begin
                    ua = alpha * ONE_Q15 + INV_S3 * beta;
                    ub = TWO_INV_S3 * beta;
                    uc = 0;
                end
                SECT_III: begin
                    ua = 0;
                    ub = INV_S3 * beta - alpha * ONE_Q15;
                    uc = -INV_S3 * beta - alpha * ONE_Q15;
                end
                default: begin
                    ua = alpha * ONE_Q15 - INV_S3 * beta;
                    ub = 0;
                    uc = -TWO_INV_S3 * beta;
                end
            endcase
        end else begin
            ua = alpha * ONE_Q15;
            ub = -HALF_Q15 * alpha + S3_HALF * beta;
            uc = -HALF_Q15 * alpha - S3_HALF * beta;
        end
        full_q30 = longint'((umax_reg == 0) ? 15'd1 : umax_reg) << 30;
        r.duty_a = scale_to_duty(ua, full_q30, drive_unipolar);
        r.duty_b = scale_to_duty(ub, full_q30, drive_unipolar);
        r.duty_c = scale_to_duty(uc, full_q30, drive_unipolar);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Result %0d: %s expected %0d, got %0d", checked_count, name,
                         want, got);
        end
    endtask

    // Result side: random back-pressure, comparison, and the idle counter.
    always @(posedge aclk) begin
        duty_triple_t want;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_duties.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction, data %h", m_axis_tdata);
            end else begin
                want = pending_duties.pop_front();
                report_field("duty_a", want.duty_a, m_axis_tdata[7:0]);
                report_field("duty_b", want.duty_b, m_axis_tdata[15:8]);
                report_field("duty_c", want.duty_c, m_axis_tdata[23:16]);
            end
            checked_count++;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** foc_phase_voltage_modulator: FAILED **");
        $finish;
    end

    task automatic send_item(input logic mode, input logic signed [15:0] uq,
                             input logic [15:0] angle);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            if (s_axis_tvalid)
                s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {angle, uq};
        s_axis_tuser <= mode;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        pending_duties.push_back(predict_duties(mode, uq, angle));
        sent_count++;
    endtask

    // Stop sending and let the pipeline empty completely.
    task automatic wait_for_duties();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_U_MAX:       umax_reg = value;
            REG_DRIVER_MODE: drive_unipolar = value[0];
            REG_PAIR_COUNT:  pole_pair_reg = value[6:0];
            default: ;
        endcase
        cfg_write_count++;
        @(posedge aclk);
    endtask

    task automatic set_idling(input int pattern);
        case (pattern)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
            default: begin send_gap_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    // Reset settings with extreme voltages, zero voltage and the quadrant angles.
    task automatic test_default_settings();
        send_item(1'b0, 16'sd0, 16'h0000);
        send_item(1'b0, 16'sd32767, 16'h0000);
        send_item(1'b1, -16'sd32768, 16'hFFFF);
        send_item(1'b1, 16'sd3072, 16'h4000);
        send_item(1'b0, -16'sd1, 16'h8000);
        send_item(1'b1, 16'sd1, 16'hC000);
        send_item(1'b0, 16'sd21845, 16'hAAAA);
        send_item(1'b1, -16'sd21846, 16'h5555);
        wait_for_duties();
    endtask

    // Unipolar mode on both sides of each 120-degree boundary.
    task automatic test_unipolar_sectors();
        write_reg(REG_DRIVER_MODE, 15'd1);
        send_item(1'b1, 16'sd2000, 16'd21845);
        send_item(1'b1, 16'sd2000, 16'd21846);
        send_item(1'b1, 16'sd2000, 16'd43690);
        send_item(1'b1, 16'sd2000, 16'd43691);
        send_item(1'b1, 16'sd2000, 16'hFFFF);
        send_item(1'b1, -16'sd2000, 16'd54613);
        wait_for_duties();
    endtask

    // Zero and extreme supply limits, zero and oversized pole counts, unused index.
    task automatic test_register_edges();
        write_reg(REG_U_MAX, 15'd0);
        send_item(1'b1, 16'sd1, 16'h1000);
        send_item(1'b0, -16'sd5, 16'h9000);
        wait_for_duties();
        write_reg(REG_U_MAX, 15'd32767);
        write_reg(REG_DRIVER_MODE, 15'd0);
        write_reg(REG_PAIR_COUNT, 15'd0);
        send_item(1'b0, 16'sd30000, 16'd12345);
        wait_for_duties();
        write_reg(REG_PAIR_COUNT, 15'd127);
        send_item(1'b0, 16'sd20000, 16'hFFFF);
        wait_for_duties();
        write_reg(REG_PAIR_COUNT, 15'd64);
        write_reg(REG_U_MAX, 15'd1);
        send_item(1'b0, 16'sd1, 16'h0401);
        wait_for_duties();
        write_reg(REG_UNUSED, 15'($urandom));
        send_item(1'b0, -16'sd2, 16'h7FFF);
        wait_for_duties();
    endtask

    task automatic test_random_traffic();
        logic [14:0]        um;
        logic [6:0]         pp;
        logic signed [15:0] uq;
        int                 lim;
        for (int round = 0; round < ROUNDS; round++) begin
            um = (round == 0) ? 15'd1 : (round == 1) ? 15'd32767 :
                 (round == 2) ? 15'd3072 : 15'($urandom_range(1, 32767));
            pp = (round == 2) ? 7'd64 : (round == 3) ? 7'd1 :
                 (round == 4) ? 7'd127 : 7'($urandom_range(1, 64));
            write_reg(REG_U_MAX, um);
            write_reg(REG_DRIVER_MODE, 15'(round % 2));
            // Upper data bits are outside the pole pair register and must be dropped.
            write_reg(REG_PAIR_COUNT, {8'($urandom), pp});
            set_idling(round % 4);
            lim = (2 * int'(um) > 32767) ? 32767 : 2 * int'(um);
            for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
                if ($urandom_range(0, 9) < 6)
                    uq = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                else
                    uq = 16'($urandom);
                if ($urandom_range(0, 49) == 0)
                    uq = 16'sd0;
                send_item(1'($urandom), uq, 16'($urandom));
                if (round % 3 == 0 && n == ITEMS_PER_ROUND / 2)
                    wait_for_duties();
            end
            wait_for_duties();
        end
    endtask

    initial begin
        umax_reg = 15'd3072;
        drive_unipolar = 1'b0;
        pole_pair_reg = 7'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_settings();
        test_unipolar_sectors();
        test_register_edges();
        test_random_traffic();

        wait_for_duties();
        $display("Sent %0d transactions and checked %0d duty triples over %0d register writes,",
                 sent_count, checked_count, cfg_write_count);
        $display("covering both driver modes, edge register values and four idling patterns.");
        if (mismatch_count == 0 && pending_duties.size() == 0) begin
            $display("** foc_phase_voltage_modulator: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_duties.size());
            $display("** foc_phase_voltage_modulator: FAILED **");
        end
        $finish;
    end

endmodule
